/* rtl/cat_map_pixel_remap_core_assert.svh */
// Assertion macros for the cat map remap core
`ifndef CAT_MAP_PIXEL_REMAP_CORE_ASSERT_SVH
`define CAT_MAP_PIXEL_REMAP_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define CMR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked during reset too
`define CMR_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CMR_ASSERT(lbl, clk, rst_n, prop, msg)
`define CMR_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

/* rtl/cmr_pkg.sv */
`default_nettype none
package cmr_pkg;

    localparam int COORD_W  = 12;
    localparam int GRAY_W   = 8;
    localparam int SIDE_W   = 13;
    localparam int ITER_W   = 20;
    localparam int CFG_W    = 20;
    localparam int MAX_SIDE = 4096;

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(512);
    localparam logic [ITER_W-1:0] ITER_RESET = '0;

    typedef enum logic {
        CFG_SIDE = 1'b0,
        CFG_ITER = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [COORD_W-1:0] src_col;
        logic [COORD_W-1:0] src_row;
        logic [GRAY_W-1:0]  gray_in;
    } t_in;

    typedef struct packed {
        logic [COORD_W-1:0] dst_col;
        logic [COORD_W-1:0] dst_row;
        logic [GRAY_W-1:0]  gray_out;
        logic               coord_error;
    } t_out;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic in_bad;
        logic iter_zero;
        logic cnt_last;
    } t_sts;

endpackage
`default_nettype wire

/* rtl/cmr_ctrl.sv */
`default_nettype none
`include "cat_map_pixel_remap_core_assert.svh"
module cmr_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire cmr_pkg::t_sts i_sts,
    output cmr_pkg::t_cmd     o_cmd,
    output logic              o_busy,
    output logic              o_done
);
    import cmr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.in_bad || i_sts.iter_zero) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                o_cmd.step = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `CMR_ASSERT(a_done_single, i_clk, i_rst_n, o_done |=> !o_done, "done held")
    `CMR_ASSERT(a_bad_fast, i_clk, i_rst_n,
        (i_start && !o_busy && i_sts.in_bad) |=> o_done, "bad coord not passed")
    `CMR_ASSERT(a_last_done, i_clk, i_rst_n,
        (o_cmd.step && i_sts.cnt_last) |=> o_done, "last step without done")
    `CMR_ASSERT(a_no_load_busy, i_clk, i_rst_n, o_busy |-> !o_cmd.load, "load while busy")
    `CMR_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> (!o_busy && !o_done), "not idle after reset")

endmodule
`default_nettype wire

/* rtl/cmr_datapath.sv */
`default_nettype none
module cmr_datapath (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire cmr_pkg::t_cmd           i_cmd,
    input  wire cmr_pkg::t_in            i_in,
    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_idx,
    input  wire logic [cmr_pkg::CFG_W-1:0] i_cfg_data,
    output cmr_pkg::t_sts                o_sts,
    output cmr_pkg::t_out                o_out
);
    import cmr_pkg::*;

    logic [SIDE_W-1:0]  r_side;
    logic [ITER_W-1:0]  r_iter;
    logic [ITER_W-1:0]  r_cnt;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [GRAY_W-1:0]  r_gray;
    logic               r_err;

    logic [SIDE_W-1:0]  w_side;
    logic [SIDE_W:0]    w_side2;
    logic [SIDE_W:0]    w_s2;
    logic [SIDE_W-1:0]  w_s1;
    logic [COORD_W-1:0] n_x;
    logic [COORD_W-1:0] n_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_RESET;
            r_iter <= ITER_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SIDE: r_side <= i_cfg_data[SIDE_W-1:0];
                CFG_ITER: r_iter <= i_cfg_data[ITER_W-1:0];
                default:  r_side <= r_side;
            endcase
        end
    end

    // effective side saturates at MAX_SIDE
    assign w_side  = (r_side > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : r_side;
    assign w_side2 = {w_side, 1'b0};

    // one map step: (2x+y) mod n, (x+y) mod n
    assign w_s2 = {1'b0, r_x, 1'b0} + {2'b00, r_y};
    assign w_s1 = {1'b0, r_x} + {1'b0, r_y};

    always_comb begin
        if (w_s2 >= w_side2) begin
            n_x = COORD_W'(w_s2 - w_side2);
        end else if (w_s2 >= {1'b0, w_side}) begin
            n_x = COORD_W'(w_s2 - {1'b0, w_side});
        end else begin
            n_x = COORD_W'(w_s2);
        end
        if (w_s1 >= w_side) begin
            n_y = COORD_W'(w_s1 - w_side);
        end else begin
            n_y = COORD_W'(w_s1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= r_iter;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt - ITER_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_in.src_col;
            r_y    <= i_in.src_row;
            r_gray <= i_in.gray_in;
            r_err  <= o_sts.in_bad;
        end else if (i_cmd.step) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    assign o_sts.in_bad    = ({1'b0, i_in.src_col} >= w_side) ||
                             ({1'b0, i_in.src_row} >= w_side);
    assign o_sts.iter_zero = (r_iter == '0);
    assign o_sts.cnt_last  = (r_cnt == ITER_W'(1));

    assign o_out.dst_col     = r_x;
    assign o_out.dst_row     = r_y;
    assign o_out.gray_out    = r_gray;
    assign o_out.coord_error = r_err;

endmodule
`default_nettype wire

/* rtl/cat_map_pixel_remap_core.sv */
`default_nettype none
// After start is taken in IDLE, the core does K map steps in RUN (K = iteration
// count), then strobes o_done in DONE; RUN is skipped when K is zero or a
// coordinate is out of range. One map step per cycle; a new start is taken only
// in IDLE. The results are shown for one cycle; the receiver cannot stall.
// Synchronous active-low reset returns to idle, side length 512, iteration count 0.
module cat_map_pixel_remap_core (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire cmr_pkg::t_in            i_in,
    output logic                         o_done,
    output cmr_pkg::t_out                o_out,
    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_idx,
    input  wire logic [cmr_pkg::CFG_W-1:0] i_cfg_data
);
    import cmr_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    cmr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    cmr_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_sts      (w_sts),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire
